/* rtl/fros_pkg.sv */
package fros_pkg;

    // Input word: one frame tick.
    typedef struct packed {
        logic        [19:0] delta_time;
        logic               target_valid;
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic signed [31:0] current_x;
        logic signed [31:0] current_y;
    } in_t;

    // Result word: the updated position.
    typedef struct packed {
        logic signed [31:0] new_x;
        logic signed [31:0] new_y;
    } out_t;

    // Smoothing modes.
    localparam logic [1:0] MODE_LINEAR = 2'd0;
    localparam logic [1:0] MODE_STEPS  = 2'd1;
    localparam logic [1:0] MODE_EXP    = 2'd2;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DECIM  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFS_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFS_Y = 3'd5;

    // One in unsigned Q1.30.
    localparam logic [30:0] Q30_ONE = 31'h4000_0000;

    // Sequencer states.
    typedef enum logic [9:0] {
        S_IDLE     = 10'b00_0000_0001,
        S_FRAMES   = 10'b00_0000_0010,
        S_LINALPHA = 10'b00_0000_0100,
        S_FRCALPHA = 10'b00_0000_1000,
        S_SCALE    = 10'b00_0001_0000,
        S_EXPINT   = 10'b00_0010_0000,
        S_SQRT     = 10'b00_0100_0000,
        S_EXPFRAC  = 10'b00_1000_0000,
        S_EXPEND   = 10'b01_0000_0000,
        S_OUT      = 10'b10_0000_0000
    } state_t;

endpackage

/* rtl/frame_rate_independent_follow_smoother_top.sv */
// Follow smoother. Every input word is one frame tick; on every decimation_count-th tick
// the position (current minus offset) is moved toward the latched target and one result
// word is produced, otherwise the tick is absorbed with no result. All math runs on one
// shared 48x16 multiplier, plus a square root unit that resolves one bit per cycle.
// Linear mode moves each axis once; step mode moves each axis min(whole frames,
// MAX_STEPS) + 1 times; exponential mode runs square-and-multiply over the whole frame
// count plus 16 roots and up to 16 products. The input is not ready while an update runs.
module frame_rate_independent_follow_smoother_top #(
    parameter int MAX_STEPS   = 64,
    parameter int COORD_WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  fros_pkg::in_t                 s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output fros_pkg::out_t                m_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [fros_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data
);

    localparam int STEP_W = $clog2(MAX_STEPS + 1);
    localparam int SAT_W  = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
    localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (SAT_W - 1)) - 64'sd1;
    localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

    fros_pkg::state_t state_reg, state_next;
    logic issued_reg, issued_next;

    // Shared multiplier.
    logic        mul_start;
    logic [47:0] mul_op_a, mul_op_b;
    logic [29:0] mul_rnd;
    logic        mul_busy_reg, mul_busy_next;
    logic        mul_done_reg, mul_done_next;
    logic [1:0]  mul_cnt_reg, mul_cnt_next;
    logic [47:0] mul_a_reg, mul_a_next, mul_b_reg, mul_b_next;
    logic [95:0] mul_acc_reg, mul_acc_next;
    logic [63:0] mul_pp;

    // Configuration.
    logic [1:0]         mode_reg, mode_next;
    logic [15:0]        gain_reg, gain_next;
    logic [9:0]         rate_reg, rate_next;
    logic [7:0]         dec_reg, dec_next;
    logic signed [31:0] offx_reg, offx_next, offy_reg, offy_next;

    // Tick state and work registers.
    logic [7:0]         tick_reg, tick_next;
    logic [31:0]        tacc_reg, tacc_next, wtacc_reg, wtacc_next;
    logic signed [31:0] tgtx_reg, tgtx_next, tgty_reg, tgty_next;
    logic [41:0]        frames_reg, frames_next, alpha_reg, alpha_next;
    logic [STEP_W-1:0]  steps_reg, steps_next, stepc_reg, stepc_next;
    logic               axis_reg, axis_next;
    logic [63:0]        curx_reg, curx_next, cury_reg, cury_next;

    // Exponential evaluation.
    logic [25:0] n_reg, n_next;
    logic [30:0] sq_reg, sq_next, p_reg, p_next, root_reg, root_next;
    logic [3:0]  bit_reg, bit_next;
    logic        phase_reg, phase_next;
    logic [61:0] rad_reg, rad_next;
    logic [32:0] rem_reg, rem_next;
    logic [30:0] res_reg, res_next;
    logic [4:0]  sqc_reg, sqc_next;
    logic        sqrt_load;

    logic           m_valid_reg, m_valid_next;
    fros_pkg::out_t m_data_reg, m_data_next;

    // Helpers.
    logic [7:0]  tick_inc;
    logic [32:0] tacc_sum;
    logic [31:0] tacc_sat;
    logic [63:0] cur_sel, tgt_sel, diff, diff_mag, move, cur_upd;
    logic        diff_neg;
    logic [30:0] q30_prod, base, p_cl;
    logic [34:0] remt, rtest;
    logic        rge;
    logic [30:0] res_step;
    logic [31:0] alpha_e;
    logic [STEP_W-1:0] step_min;
    logic [63:0] sum_x, sum_y, sat_x, sat_y;

    assign s_ready   = (state_reg == fros_pkg::S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // Multiplier: one 16-bit digit of b per cycle, accumulator preloaded with rounding.
    assign mul_pp = mul_a_reg * mul_b_reg[15:0];

    always_comb begin
        mul_busy_next = mul_busy_reg;
        mul_done_next = 1'b0;
        mul_cnt_next  = mul_cnt_reg;
        mul_a_next    = mul_a_reg;
        mul_b_next    = mul_b_reg;
        mul_acc_next  = mul_acc_reg;
        if (mul_start) begin
            mul_busy_next = 1'b1;
            mul_cnt_next  = 2'd0;
            mul_a_next    = mul_op_a;
            mul_b_next    = mul_op_b;
            mul_acc_next  = {66'd0, mul_rnd};
        end else if (mul_busy_reg) begin
            mul_acc_next = mul_acc_reg + (96'(mul_pp) << {mul_cnt_reg, 4'b0000});
            mul_b_next   = mul_b_reg >> 16;
            mul_cnt_next = mul_cnt_reg + 2'd1;
            if (mul_cnt_reg == 2'd2) begin
                mul_busy_next = 1'b0;
                mul_done_next = 1'b1;
            end
        end
    end

    // Datapath helpers.
    always_comb begin
        tick_inc = tick_reg + 8'd1;
        tacc_sum = {1'b0, tacc_reg} + {13'd0, s_data.delta_time};
        tacc_sat = tacc_sum[32] ? 32'hFFFF_FFFF : tacc_sum[31:0];
        cur_sel  = axis_reg ? cury_reg : curx_reg;
        tgt_sel  = axis_reg ? {{32{tgty_reg[31]}}, tgty_reg} : {{32{tgtx_reg[31]}}, tgtx_reg};
        diff     = tgt_sel - cur_sel;
        diff_neg = diff[63];
        diff_mag = diff_neg ? (64'd0 - diff) : diff;
        move     = mul_acc_reg[79:16];
        cur_upd  = diff_neg ? (cur_sel - move) : (cur_sel + move);
        q30_prod = mul_acc_reg[60:30];
        base     = {17'h10000 - {1'b0, gain_reg}, 14'd0};
        p_cl     = (p_reg > fros_pkg::Q30_ONE) ? fros_pkg::Q30_ONE : p_reg;
        alpha_e  = ({1'b0, fros_pkg::Q30_ONE} - {1'b0, p_cl} + 32'd8192) >> 14;
        remt     = {rem_reg, rad_reg[61:60]};
        rtest    = {2'b00, res_reg, 2'b01};
        rge      = (remt >= rtest);
        res_step = {res_reg[29:0], rge};
        if (frames_reg[41:16] > 26'(MAX_STEPS)) begin
            step_min = STEP_W'(MAX_STEPS);
        end else begin
            step_min = frames_reg[16 +: STEP_W];
        end
        sum_x = curx_reg + {{32{offx_reg[31]}}, offx_reg};
        sum_y = cury_reg + {{32{offy_reg[31]}}, offy_reg};
        sat_x = ($signed(sum_x) > SAT_HI) ? SAT_HI :
                (($signed(sum_x) < SAT_LO) ? SAT_LO : sum_x);
        sat_y = ($signed(sum_y) > SAT_HI) ? SAT_HI :
                (($signed(sum_y) < SAT_LO) ? SAT_LO : sum_y);
    end

    // Sequencer.
    always_comb begin
        state_next   = state_reg;
        issued_next  = issued_reg;
        mul_start    = 1'b0;
        mul_op_a     = 48'd0;
        mul_op_b     = 48'd0;
        mul_rnd      = 30'd0;
        mode_next    = mode_reg;
        gain_next    = gain_reg;
        rate_next    = rate_reg;
        dec_next     = dec_reg;
        offx_next    = offx_reg;
        offy_next    = offy_reg;
        tick_next    = tick_reg;
        tacc_next    = tacc_reg;
        wtacc_next   = wtacc_reg;
        tgtx_next    = tgtx_reg;
        tgty_next    = tgty_reg;
        frames_next  = frames_reg;
        alpha_next   = alpha_reg;
        steps_next   = steps_reg;
        stepc_next   = stepc_reg;
        axis_next    = axis_reg;
        curx_next    = curx_reg;
        cury_next    = cury_reg;
        n_next       = n_reg;
        sq_next      = sq_reg;
        p_next       = p_reg;
        root_next    = root_reg;
        bit_next     = bit_reg;
        phase_next   = phase_reg;
        rad_next     = rad_reg;
        rem_next     = rem_reg;
        res_next     = res_reg;
        sqc_next     = sqc_reg;
        sqrt_load    = 1'b0;
        m_valid_next = m_valid_reg & ~m_ready;
        m_data_next  = m_data_reg;

        // Configuration writes.
        if (cfg_valid) begin
            case (cfg_index)
                fros_pkg::CFG_MODE:   mode_next = cfg_data[1:0];
                fros_pkg::CFG_GAIN:   gain_next = cfg_data[15:0];
                fros_pkg::CFG_RATE:   rate_next = cfg_data[9:0];
                fros_pkg::CFG_DECIM:  dec_next  = cfg_data[7:0];
                fros_pkg::CFG_OFFS_X: offx_next = cfg_data;
                fros_pkg::CFG_OFFS_Y: offy_next = cfg_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            fros_pkg::S_IDLE: begin
                if (s_valid) begin
                    if (s_data.target_valid) begin
                        tgtx_next = s_data.target_x;
                        tgty_next = s_data.target_y;
                    end
                    if (tick_inc < dec_reg) begin
                        tick_next = tick_inc;
                        tacc_next = tacc_sat;
                    end else begin
                        tick_next  = 8'd0;
                        tacc_next  = 32'd0;
                        wtacc_next = tacc_sat;
                        curx_next  = {{32{s_data.current_x[31]}}, s_data.current_x}
                                   - {{32{offx_reg[31]}}, offx_reg};
                        cury_next  = {{32{s_data.current_y[31]}}, s_data.current_y}
                                   - {{32{offy_reg[31]}}, offy_reg};
                        state_next = fros_pkg::S_FRAMES;
                    end
                end
            end

            // Accumulated frames = time * rate, exact.
            fros_pkg::S_FRAMES: begin
                mul_op_a = {16'd0, wtacc_reg};
                mul_op_b = {38'd0, rate_reg};
                if (!issued_reg) begin
                    mul_start   = 1'b1;
                    issued_next = 1'b1;
                end else if (mul_done_reg) begin
                    issued_next = 1'b0;
                    frames_next = mul_acc_reg[41:0];
                    axis_next   = 1'b0;
                    case (mode_reg)
                        fros_pkg::MODE_LINEAR: state_next = fros_pkg::S_LINALPHA;
                        fros_pkg::MODE_STEPS:  state_next = fros_pkg::S_FRCALPHA;
                        fros_pkg::MODE_EXP: begin
                            n_next     = mul_acc_reg[41:16];
                            sq_next    = base;
                            p_next     = fros_pkg::Q30_ONE;
                            root_next  = base;
                            phase_next = 1'b0;
                            state_next = fros_pkg::S_EXPINT;
                        end
                        default: state_next = fros_pkg::S_OUT;
                    endcase
                end
            end

            // Linear: alpha = k * F, rounded.
            fros_pkg::S_LINALPHA: begin
                mul_op_a = {32'd0, gain_reg};
                mul_op_b = {6'd0, frames_reg};
                mul_rnd  = 30'h8000;
                if (!issued_reg) begin
                    mul_start   = 1'b1;
                    issued_next = 1'b1;
                end else if (mul_done_reg) begin
                    issued_next = 1'b0;
                    alpha_next  = mul_acc_reg[57:16];
                    steps_next  = '0;
                    stepc_next  = '0;
                    state_next  = fros_pkg::S_SCALE;
                end
            end

            // Steps: fractional step alpha, and the capped whole-step count.
            fros_pkg::S_FRCALPHA: begin
                mul_op_a = {32'd0, gain_reg};
                mul_op_b = {32'd0, frames_reg[15:0]};
                mul_rnd  = 30'h8000;
                if (!issued_reg) begin
                    mul_start   = 1'b1;
                    issued_next = 1'b1;
                end else if (mul_done_reg) begin
                    issued_next = 1'b0;
                    alpha_next  = mul_acc_reg[57:16];
                    steps_next  = step_min;
                    stepc_next  = step_min;
                    state_next  = fros_pkg::S_SCALE;
                end
            end

            // One move of the current axis: whole steps use k, the last uses alpha.
            fros_pkg::S_SCALE: begin
                mul_op_a = diff_mag[47:0];
                mul_op_b = (stepc_reg != '0) ? {32'd0, gain_reg} : {6'd0, alpha_reg};
                mul_rnd  = 30'h8000;
                if (!issued_reg) begin
                    mul_start   = 1'b1;
                    issued_next = 1'b1;
                end else if (mul_done_reg) begin
                    issued_next = 1'b0;
                    if (axis_reg) begin
                        cury_next = cur_upd;
                    end else begin
                        curx_next = cur_upd;
                    end
                    if (stepc_reg != '0) begin
                        stepc_next = stepc_reg - STEP_W'(1);
                    end else if (!axis_reg) begin
                        axis_next  = 1'b1;
                        stepc_next = steps_reg;
                    end else begin
                        state_next = fros_pkg::S_OUT;
                    end
                end
            end

            // Integer power by square-and-multiply.
            fros_pkg::S_EXPINT: begin
                mul_op_a = phase_reg ? {17'd0, sq_reg} : {17'd0, p_reg};
                mul_op_b = {17'd0, sq_reg};
                mul_rnd  = 30'h2000_0000;
                if (!issued_reg && (n_reg == 26'd0 || p_reg == 31'd0)) begin
                    bit_next   = 4'd15;
                    sqrt_load  = 1'b1;
                    state_next = fros_pkg::S_SQRT;
                end else if (!issued_reg && !phase_reg && !n_reg[0]) begin
                    phase_next = 1'b1;
                end else if (!issued_reg) begin
                    mul_start   = 1'b1;
                    issued_next = 1'b1;
                end else if (mul_done_reg) begin
                    issued_next = 1'b0;
                    if (phase_reg) begin
                        sq_next    = q30_prod;
                        n_next     = n_reg >> 1;
                        phase_next = 1'b0;
                    end else begin
                        p_next     = q30_prod;
                        phase_next = 1'b1;
                    end
                end
            end

            // Floor square root of root * 2^30, one result bit per cycle.
            fros_pkg::S_SQRT: begin
                rad_next = rad_reg << 2;
                rem_next = rge ? 33'(remt - rtest) : 33'(remt);
                res_next = res_step;
                sqc_next = sqc_reg + 5'd1;
                if (sqc_reg == 5'd30) begin
                    root_next = res_step;
                    if (frames_reg[bit_reg]) begin
                        state_next = fros_pkg::S_EXPFRAC;
                    end else if (bit_reg == 4'd0) begin
                        state_next = fros_pkg::S_EXPEND;
                    end else begin
                        bit_next  = bit_reg - 4'd1;
                        sqrt_load = 1'b1;
                    end
                end
            end

            // Fold one fractional root into the power.
            fros_pkg::S_EXPFRAC: begin
                mul_op_a = {17'd0, p_reg};
                mul_op_b = {17'd0, root_reg};
                mul_rnd  = 30'h2000_0000;
                if (!issued_reg) begin
                    mul_start   = 1'b1;
                    issued_next = 1'b1;
                end else if (mul_done_reg) begin
                    issued_next = 1'b0;
                    p_next      = q30_prod;
                    if (bit_reg == 4'd0) begin
                        state_next = fros_pkg::S_EXPEND;
                    end else begin
                        bit_next   = bit_reg - 4'd1;
                        sqrt_load  = 1'b1;
                        state_next = fros_pkg::S_SQRT;
                    end
                end
            end

            // alpha = 1 - power, back to Q16.16.
            fros_pkg::S_EXPEND: begin
                alpha_next = {25'd0, alpha_e[16:0]};
                steps_next = '0;
                stepc_next = '0;
                axis_next  = 1'b0;
                state_next = fros_pkg::S_SCALE;
            end

            // Load the output register once it is free.
            fros_pkg::S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next      = 1'b1;
                    m_data_next.new_x = sat_x[31:0];
                    m_data_next.new_y = sat_y[31:0];
                    state_next        = fros_pkg::S_IDLE;
                end
            end

            default: state_next = fros_pkg::S_IDLE;
        endcase

        // Start a new root from the latest root value.
        if (sqrt_load) begin
            rad_next = {1'b0, root_next, 30'd0};
            rem_next = 33'd0;
            res_next = 31'd0;
            sqc_next = 5'd0;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= fros_pkg::S_IDLE;
            issued_reg   <= 1'b0;
            mul_busy_reg <= 1'b0;
            mul_done_reg <= 1'b0;
            mul_cnt_reg  <= 2'd0;
            mode_reg     <= fros_pkg::MODE_LINEAR;
            gain_reg     <= 16'd32768;
            rate_reg     <= 10'd60;
            dec_reg      <= 8'd1;
            offx_reg     <= 32'sd0;
            offy_reg     <= 32'sd0;
            tick_reg     <= 8'd0;
            tacc_reg     <= 32'd0;
            tgtx_reg     <= 32'sd0;
            tgty_reg     <= 32'sd0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            issued_reg   <= issued_next;
            mul_busy_reg <= mul_busy_next;
            mul_done_reg <= mul_done_next;
            mul_cnt_reg  <= mul_cnt_next;
            mode_reg     <= mode_next;
            gain_reg     <= gain_next;
            rate_reg     <= rate_next;
            dec_reg      <= dec_next;
            offx_reg     <= offx_next;
            offy_reg     <= offy_next;
            tick_reg     <= tick_next;
            tacc_reg     <= tacc_next;
            tgtx_reg     <= tgtx_next;
            tgty_reg     <= tgty_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload and work registers.
    always_ff @(posedge aclk) begin
        mul_a_reg   <= mul_a_next;
        mul_b_reg   <= mul_b_next;
        mul_acc_reg <= mul_acc_next;
        wtacc_reg   <= wtacc_next;
        frames_reg  <= frames_next;
        alpha_reg   <= alpha_next;
        steps_reg   <= steps_next;
        stepc_reg   <= stepc_next;
        axis_reg    <= axis_next;
        curx_reg    <= curx_next;
        cury_reg    <= cury_next;
        n_reg       <= n_next;
        sq_reg      <= sq_next;
        p_reg       <= p_next;
        root_reg    <= root_next;
        bit_reg     <= bit_next;
        phase_reg   <= phase_next;
        rad_reg     <= rad_next;
        rem_reg     <= rem_next;
        res_reg     <= res_next;
        sqc_reg     <= sqc_next;
        m_data_reg  <= m_data_next;
    end

    // A finished product only ever answers a request from the sequencer.
    a_done_issued: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done_reg |-> issued_reg)
        else $error("multiplier result without a pending request");

    // The multiplier is never restarted while it is still accumulating.
    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_start |-> !mul_busy_reg)
        else $error("multiplier started while busy");

    // While an update runs the tick counter and time sum are already cleared.
    a_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != fros_pkg::S_IDLE) |-> (tick_reg == 8'd0 && tacc_reg == 32'd0))
        else $error("tick state not cleared during an update");

    // The power stays within one in Q1.30.
    a_power_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == fros_pkg::S_EXPINT) |-> (p_reg <= fros_pkg::Q30_ONE
                                               && sq_reg <= fros_pkg::Q30_ONE))
        else $error("power above one");

    // Every update ends in a result word in the cycle after it leaves the output stage.
    a_out_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == fros_pkg::S_OUT && state_next == fros_pkg::S_IDLE) |=> m_valid_reg)
        else $error("result word not presented");

endmodule
